// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the text console checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcw checker: same-cycle property failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcw checker: next-cycle property failed");

`endif

// ===== src/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared codes, constants and types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ERROR   = 8'h45;

  // Configuration register indexes and reset values
  localparam logic CFG_DEFAULT_ATTR = 1'b0;
  localparam logic CFG_ERROR_ATTR   = 1'b1;
  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

  // One result transaction
  typedef struct packed {
    logic signed [15:0] next_offset;
    logic               out_of_range;
    logic [7:0]         cell_char;
    logic [7:0]         cell_attr;
  } tcw_res_t;

endpackage

// ===== src/tcw_if.sv =====
// ---------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: command and result.
// ---------------------------------------------------------------------------
interface tcw_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        char_code;
  logic signed [7:0] col_pos;
  logic signed [7:0] row_pos;
  logic [7:0]        attribute;

  modport source (output valid, cmd, char_code, col_pos, row_pos, attribute, input ready);
  modport sink   (input valid, cmd, char_code, col_pos, row_pos, attribute, output ready);
endinterface

interface tcw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] next_offset;
  logic               out_of_range;
  logic [7:0]         cell_char;
  logic [7:0]         cell_attr;

  modport source (output valid, next_offset, out_of_range, cell_char, cell_attr, input ready);
  modport sink   (input valid, next_offset, out_of_range, cell_char, cell_attr, output ready);
endinterface

// ===== src/tcw_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/tcw_cell_unit.sv =====
// ---------------------------------------------------------------------------
// tcw_cell_unit
// Shared linear-index unit: row * COLS + col on signed screen coordinates.
// ---------------------------------------------------------------------------
module tcw_cell_unit #(
  parameter int SCREEN_COLS = 80
) (
  input  logic signed [7:0]  row_i,
  input  logic signed [7:0]  col_i,
  output logic signed [15:0] lin_o
);

  localparam logic signed [15:0] COLS_W = 16'(SCREEN_COLS);

  logic signed [15:0] row_ext;
  logic signed [15:0] col_ext;

  // Constant multiply and add; result always fits in 15 signed bits
  assign row_ext = {{8{row_i[7]}}, row_i};
  assign col_ext = {{8{col_i[7]}}, col_i};
  assign lin_o   = row_ext * COLS_W + col_ext;

endmodule

// ===== src/text_console_writer_core.sv =====
// ---------------------------------------------------------------------------
// text_console_writer_core
// Text-mode screen of character/attribute cells with a cursor; put, clear
// and read commands are run by a small sequencer around one cell RAM.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  req_i    | in  | valid / ready    | cmd, char_code, col_pos, row_pos, attribute
//  rsp_o    | out | valid / ready    | next_offset, out_of_range, cell_char, cell_attr
//  cfg      | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// A put runs accept, index, action, offset and result; an out-of-range put
// skips offset. A read runs accept, index, action, read wait and result; an
// out-of-range read skips read wait; cmd 3 goes from accept to result. A put
// that runs past the last cell adds a scroll (row copy, then a blank row).
// Clear runs a clearing pass, then the result. After reset a clearing pass
// zeroes the RAM before req_i.ready rises. A result waits in an output
// register, so the next command is taken while rsp_o is stalled.
// ---------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  tcw_in_if.sink     req_i,
  tcw_out_if.source  rsp_o
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam logic signed [8:0] COLS_S = 9'(SCREEN_COLS);
  localparam logic signed [8:0] ROWS_S = 9'(SCREEN_ROWS);

  // Sequencer states
  localparam logic [3:0] ST_FILL   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LIN    = 4'd2;
  localparam logic [3:0] ST_ACT    = 4'd3;
  localparam logic [3:0] ST_OFF    = 4'd4;
  localparam logic [3:0] ST_RDWAIT = 4'd5;
  localparam logic [3:0] ST_COPY   = 4'd6;
  localparam logic [3:0] ST_BLANK  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic              init_q, init_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]        dflt_attr_q, err_attr_q;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic              out_valid_q, out_valid_d;
  tcw_res_t          out_q, out_d;
  tcw_res_t          res_q, res_d;

  // Latched command fields
  logic [1:0]         cmd_q, cmd_d;
  logic [7:0]         ch_q, ch_d;
  logic [7:0]         attr_q, attr_d;
  logic signed [7:0]  row_q, row_d;
  logic signed [7:0]  col_q, col_d;
  logic               err_q, err_d;
  logic               rdok_q, rdok_d;
  logic signed [15:0] lin_q, lin_d;

  // RAM and shared unit hookup
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;
  logic signed [7:0]  unit_row, unit_col;
  logic signed [15:0] unit_lin;

  // Input decode
  logic in_acc, col_big, row_big, pos_neg;
  logic [7:0] nc_full, nr_full;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign col_big = $signed({req_i.col_pos[7], req_i.col_pos}) >= COLS_S;
  assign row_big = $signed({req_i.row_pos[7], req_i.row_pos}) >= ROWS_S;
  assign pos_neg = req_i.col_pos[7] || req_i.row_pos[7];

  // Next cursor candidates (row_q/col_q are non-negative on this path)
  assign nc_full = 8'(col_q) + 8'd1;
  assign nr_full = 8'(row_q) + 8'd1;

  tcw_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared index unit: command position, or cursor when forming the offset
  assign unit_row = (state_q == ST_OFF) ? 8'(cur_row_q) : row_q;
  assign unit_col = (state_q == ST_OFF) ? 8'(cur_col_q) : col_q;

  tcw_cell_unit #(.SCREEN_COLS(SCREEN_COLS)) u_cell_unit (
    .row_i (unit_row),
    .col_i (unit_col),
    .lin_o (unit_lin)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_attr_q <= DEFAULT_ATTR_RST;
      err_attr_q  <= ERROR_ATTR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DEFAULT_ATTR) begin
        dflt_attr_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_ERROR_ATTR) begin
        err_attr_q <= cfg_data_i;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    res_d     = res_q;
    cmd_d     = cmd_q;
    ch_d      = ch_q;
    attr_d    = attr_q;
    row_d     = row_q;
    col_d     = col_q;
    err_d     = err_q;
    rdok_d    = rdok_q;
    lin_d     = lin_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[ADDR_W-1:0];
    ram_wdata = 16'h0000;
    ram_raddr = cnt_q[ADDR_W-1:0];
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;

    case (state_q)
      // Clearing pass: zeroes after reset, spaces for a clear command
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = init_q ? 16'h0000 : {dflt_attr_q, CHAR_SPACE};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cmd_d  = req_i.cmd;
          ch_d   = req_i.char_code;
          attr_d = (req_i.attribute == 8'd0) ? dflt_attr_q : req_i.attribute;
          err_d  = col_big || row_big;
          rdok_d = !pos_neg && !col_big && !row_big;
          res_d  = '0;
          if (req_i.cmd == CMD_PUT && !(col_big || row_big) && pos_neg) begin
            row_d = 8'(cur_row_q);
            col_d = 8'(cur_col_q);
          end else begin
            row_d = req_i.row_pos;
            col_d = req_i.col_pos;
          end
          case (req_i.cmd)
            CMD_PUT, CMD_READ: state_d = ST_LIN;
            CMD_CLEAR: begin
              cnt_d     = '0;
              cur_row_d = '0;
              cur_col_d = '0;
              state_d   = ST_FILL;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_LIN: begin
        lin_d   = unit_lin;
        state_d = ST_ACT;
      end

      ST_ACT: begin
        case (cmd_q)
          CMD_PUT: begin
            if (err_q) begin
              // Error mark in the last cell, cursor untouched
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(CELL_COUNT - 1);
              ram_wdata = {err_attr_q, CHAR_ERROR};
              res_d.next_offset  = {lin_q[14:0], 1'b0};
              res_d.out_of_range = 1'b1;
              state_d = ST_DONE;
            end else begin
              logic [7:0] nr;
              logic [7:0] nc;
              nr = nr_full;
              nc = 8'd0;
              if (ch_q != CHAR_NEWLINE) begin
                ram_we    = 1'b1;
                ram_waddr = lin_q[ADDR_W-1:0];
                ram_wdata = {attr_q, ch_q};
                if (nc_full != 8'(SCREEN_COLS)) begin
                  nr = 8'(row_q);
                  nc = nc_full;
                end
              end
              cur_col_d = nc[COL_W-1:0];
              if (nr == 8'(SCREEN_ROWS)) begin
                // Ran past the last cell: scroll up one row
                cur_row_d = ROW_W'(SCREEN_ROWS - 1);
                cnt_d     = CNT_W'(SCREEN_COLS);
                state_d   = ST_COPY;
              end else begin
                cur_row_d = nr[ROW_W-1:0];
                state_d   = ST_OFF;
              end
            end
          end
          CMD_READ: begin
            if (rdok_q) begin
              ram_raddr = lin_q[ADDR_W-1:0];
              state_d   = ST_RDWAIT;
            end else begin
              res_d.out_of_range = 1'b1;
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end

      // Copy cell i+COLS to cell i, one read and one write per cycle
      ST_COPY: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q != CNT_W'(CELL_COUNT)) begin
          ram_raddr = cnt_q[ADDR_W-1:0];
          pend_d    = 1'b1;
          wr_addr_d = ADDR_W'(cnt_q - CNT_W'(SCREEN_COLS));
          cnt_d     = cnt_q + 1'b1;
        end else begin
          cnt_d   = CNT_W'(CELL_COUNT - SCREEN_COLS);
          state_d = ST_BLANK;
        end
      end

      // Zero the last row
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = 16'h0000;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          state_d = ST_OFF;
        end
      end

      ST_OFF: begin
        res_d.next_offset = {unit_lin[14:0], 1'b0};
        state_d = ST_DONE;
      end

      ST_RDWAIT: begin
        res_d.cell_char = ram_rdata[7:0];
        res_d.cell_attr = ram_rdata[15:8];
        state_d = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    res_q     <= res_d;
    out_q     <= out_d;
    cmd_q     <= cmd_d;
    ch_q      <= ch_d;
    attr_q    <= attr_d;
    row_q     <= row_d;
    col_q     <= col_d;
    err_q     <= err_d;
    rdok_q    <= rdok_d;
    lin_q     <= lin_d;
  end

  // Result channel
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.next_offset  = out_q.next_offset;
  assign rsp_o.out_of_range = out_q.out_of_range;
  assign rsp_o.cell_char    = out_q.cell_char;
  assign rsp_o.cell_attr    = out_q.cell_attr;

endmodule

// ===== src/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] next_offset,
  input logic        out_of_range,
  input logic [7:0]  cell_char,
  input logic [7:0]  cell_attr
);

  logic has_data;

  assign has_data = (cell_char != 8'd0) || (cell_attr != 8'd0);

  // A stalled result stays offered
  `TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // One command at a time: busy right after a transaction is taken
  `TCW_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // Offsets count bytes of two-byte cells
  `TCW_ASSERT_SAME(a_offset_even, out_valid, !next_offset[0])

  // Only an in-range read returns cell contents, with a zero offset
  `TCW_ASSERT_SAME(a_read_shape, out_valid && has_data, next_offset == 16'd0 && !out_of_range)

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (req_i.valid),
  .in_ready     (req_i.ready),
  .out_valid    (rsp_o.valid),
  .out_ready    (rsp_o.ready),
  .next_offset  (rsp_o.next_offset),
  .out_of_range (rsp_o.out_of_range),
  .cell_char    (rsp_o.cell_char),
  .cell_attr    (rsp_o.cell_attr)
);
